// ===== rtl/i2c_master_bit_engine_core_macros.svh =====
// Assertion macros used by the checker of the I2C master bit engine.
`ifndef I2C_MASTER_BIT_ENGINE_CORE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_MACROS_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define MBE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("i2c_mbe assertion failed");

// Implication in the next cycle, disabled while reset is asserted.
`define MBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("i2c_mbe assertion failed");

// Implication in the next cycle that also holds across reset.
`define MBE_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("i2c_mbe assertion failed");

`endif

// ===== rtl/i2c_mbe_pkg.sv =====
// Types and constants shared by the I2C master bit engine modules.
package i2c_mbe_pkg;

    localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd5000;
    localparam logic [7:0]  ADDR_SPACE_LIM    = 8'd128;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_START     = 3'd1,
        OP_STOP      = 3'd2,
        OP_WRITE     = 3'd3,
        OP_READ_ACK  = 3'd4,
        OP_READ_NACK = 3'd5,
        OP_PROBE     = 3'd6,
        OP_COUNT     = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BUSY  = 2'd1,
        ST_ERROR = 2'd2,
        ST_NACK  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'd0,
        PH_S1    = 5'd1,
        PH_S2    = 5'd2,
        PH_S3    = 5'd3,
        PH_S4    = 5'd4,
        PH_S5    = 5'd5,
        PH_BDATA = 5'd6,
        PH_BHIGH = 5'd7,
        PH_BLOW  = 5'd8,
        PH_A1    = 5'd9,
        PH_A2    = 5'd10,
        PH_A3    = 5'd11,
        PH_R0    = 5'd12,
        PH_RHIGH = 5'd13,
        PH_RLOW  = 5'd14,
        PH_K1    = 5'd15,
        PH_K2    = 5'd16,
        PH_K3    = 5'd17,
        PH_P1    = 5'd18,
        PH_P2    = 5'd19,
        PH_P3    = 5'd20
    } phase_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] wr_data;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        status_t    status;
        logic [7:0] rd_data;
        logic [7:0] device_count;
    } res_t;

endpackage

// ===== rtl/i2c_mbe_in_stage.sv =====
// Input register that holds one accepted item until the sequencer takes it.
module i2c_mbe_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  i2c_mbe_pkg::item_t item_in,
    input  logic               adv,
    output logic               item_valid,
    output i2c_mbe_pkg::item_t item_out
);

    logic               valid_reg;
    i2c_mbe_pkg::item_t item_reg;

    assign s_ready    = !valid_reg || adv;
    assign item_valid = valid_reg;
    assign item_out   = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_in;
        end
    end

endmodule

// ===== rtl/i2c_mbe_seq.sv =====
// Line sequencer state machine that performs one line action per item.
module i2c_mbe_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  i2c_mbe_pkg::item_t item,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    output i2c_mbe_pkg::res_t  res
);

    i2c_mbe_pkg::phase_t  phase_reg, phase_next, eff_phase;
    i2c_mbe_pkg::op_t     cmd_reg, cmd_pre;
    i2c_mbe_pkg::status_t status_reg, status_next;
    logic [3:0]  bit_reg, bit_pre, bit_next, bit_inc;
    logic [7:0]  shift_reg, shift_pre, shift_next;
    logic [15:0] ack_reg, ack_next, timeout_reg;
    logic [6:0]  paddr_reg, paddr_pre, paddr_next;
    logic [7:0]  found_reg, found_pre, found_next, found_inc;
    logic        pfail_reg, pfail_pre, pfail_next;
    logic        scl_reg, scl_next, sda_reg, sda_next;
    logic [7:0]  rd_reg, rd_next, cnt_reg, cnt_next;
    logic        start_cmd, bit_done, paddr_last, ack_expire, done;

    assign start_cmd  = (phase_reg == i2c_mbe_pkg::PH_IDLE) && (item.op != i2c_mbe_pkg::OP_TICK);
    assign bit_inc    = bit_pre + 4'd1;
    assign bit_done   = bit_inc >= 4'd8;
    assign paddr_last = ({1'b0, paddr_pre} + 8'd1) >= i2c_mbe_pkg::ADDR_SPACE_LIM;
    assign ack_expire = ack_reg <= 16'd1;
    assign found_inc  = found_pre + {7'd0, !pfail_pre};

    // Command entry: load the command registers and pick the first phase.
    always_comb begin
        cmd_pre   = cmd_reg;
        shift_pre = shift_reg;
        bit_pre   = bit_reg;
        paddr_pre = paddr_reg;
        found_pre = found_reg;
        pfail_pre = pfail_reg;
        eff_phase = phase_reg;
        if (start_cmd) begin
            cmd_pre   = item.op;
            pfail_pre = 1'b0;
            unique case (item.op)
                i2c_mbe_pkg::OP_START: begin
                    eff_phase = i2c_mbe_pkg::PH_S1;
                end
                i2c_mbe_pkg::OP_STOP: begin
                    eff_phase = i2c_mbe_pkg::PH_P1;
                end
                i2c_mbe_pkg::OP_WRITE: begin
                    shift_pre = item.wr_data;
                    bit_pre   = 4'd0;
                    eff_phase = i2c_mbe_pkg::PH_BDATA;
                end
                i2c_mbe_pkg::OP_READ_ACK, i2c_mbe_pkg::OP_READ_NACK: begin
                    eff_phase = i2c_mbe_pkg::PH_R0;
                end
                i2c_mbe_pkg::OP_PROBE: begin
                    shift_pre = item.wr_data;
                    eff_phase = i2c_mbe_pkg::PH_S1;
                end
                i2c_mbe_pkg::OP_COUNT: begin
                    paddr_pre = 7'd0;
                    found_pre = 8'd0;
                    eff_phase = i2c_mbe_pkg::PH_S1;
                end
                i2c_mbe_pkg::OP_TICK: begin
                    eff_phase = phase_reg;
                end
            endcase
        end
    end

    // Next phase.
    always_comb begin
        unique case (eff_phase)
            i2c_mbe_pkg::PH_S1:    phase_next = i2c_mbe_pkg::PH_S2;
            i2c_mbe_pkg::PH_S2:    phase_next = i2c_mbe_pkg::PH_S3;
            i2c_mbe_pkg::PH_S3: begin
                if (!item.sda_in) begin
                    phase_next = (cmd_pre == i2c_mbe_pkg::OP_START) ? i2c_mbe_pkg::PH_IDLE
                                                                     : i2c_mbe_pkg::PH_P1;
                end else begin
                    phase_next = i2c_mbe_pkg::PH_S4;
                end
            end
            i2c_mbe_pkg::PH_S4:    phase_next = i2c_mbe_pkg::PH_S5;
            i2c_mbe_pkg::PH_S5: begin
                if (item.sda_in) begin
                    phase_next = (cmd_pre == i2c_mbe_pkg::OP_START) ? i2c_mbe_pkg::PH_IDLE
                                                                     : i2c_mbe_pkg::PH_P1;
                end else if (cmd_pre == i2c_mbe_pkg::OP_START) begin
                    phase_next = i2c_mbe_pkg::PH_IDLE;
                end else begin
                    phase_next = i2c_mbe_pkg::PH_BDATA;
                end
            end
            i2c_mbe_pkg::PH_BDATA: phase_next = i2c_mbe_pkg::PH_BHIGH;
            i2c_mbe_pkg::PH_BHIGH: phase_next = i2c_mbe_pkg::PH_BLOW;
            i2c_mbe_pkg::PH_BLOW:
                phase_next = bit_done ? i2c_mbe_pkg::PH_A1 : i2c_mbe_pkg::PH_BDATA;
            i2c_mbe_pkg::PH_A1:    phase_next = i2c_mbe_pkg::PH_A2;
            i2c_mbe_pkg::PH_A2:    phase_next = i2c_mbe_pkg::PH_A3;
            i2c_mbe_pkg::PH_A3: begin
                if (!item.sda_in) begin
                    phase_next = (cmd_pre == i2c_mbe_pkg::OP_WRITE) ? i2c_mbe_pkg::PH_IDLE
                                                                     : i2c_mbe_pkg::PH_P1;
                end else if (ack_expire) begin
                    phase_next = i2c_mbe_pkg::PH_P2;
                end else begin
                    phase_next = i2c_mbe_pkg::PH_A3;
                end
            end
            i2c_mbe_pkg::PH_R0:    phase_next = i2c_mbe_pkg::PH_RHIGH;
            i2c_mbe_pkg::PH_RHIGH: phase_next = i2c_mbe_pkg::PH_RLOW;
            i2c_mbe_pkg::PH_RLOW:
                phase_next = bit_done ? i2c_mbe_pkg::PH_K1 : i2c_mbe_pkg::PH_RHIGH;
            i2c_mbe_pkg::PH_K1:    phase_next = i2c_mbe_pkg::PH_K2;
            i2c_mbe_pkg::PH_K2:    phase_next = i2c_mbe_pkg::PH_K3;
            i2c_mbe_pkg::PH_K3:    phase_next = i2c_mbe_pkg::PH_IDLE;
            i2c_mbe_pkg::PH_P1:    phase_next = i2c_mbe_pkg::PH_P2;
            i2c_mbe_pkg::PH_P2:    phase_next = i2c_mbe_pkg::PH_P3;
            i2c_mbe_pkg::PH_P3: begin
                if (cmd_pre == i2c_mbe_pkg::OP_COUNT && !paddr_last) begin
                    phase_next = i2c_mbe_pkg::PH_S1;
                end else begin
                    phase_next = i2c_mbe_pkg::PH_IDLE;
                end
            end
            default:               phase_next = i2c_mbe_pkg::PH_IDLE;
        endcase
    end

    // Line drive, datapath registers and completion status.
    always_comb begin
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        shift_next  = shift_pre;
        bit_next    = bit_pre;
        ack_next    = ack_reg;
        paddr_next  = paddr_pre;
        found_next  = found_pre;
        pfail_next  = pfail_pre;
        status_next = status_reg;
        rd_next     = rd_reg;
        cnt_next    = cnt_reg;
        done        = 1'b0;
        unique case (eff_phase)
            i2c_mbe_pkg::PH_S1: sda_next = 1'b1;
            i2c_mbe_pkg::PH_S2: scl_next = 1'b1;
            i2c_mbe_pkg::PH_S3: begin
                if (!item.sda_in) begin
                    if (cmd_pre == i2c_mbe_pkg::OP_START) begin
                        status_next = i2c_mbe_pkg::ST_BUSY;
                        done        = 1'b1;
                    end else begin
                        pfail_next = 1'b1;
                    end
                end else begin
                    sda_next = 1'b0;
                end
            end
            i2c_mbe_pkg::PH_S4: scl_next = 1'b0;
            i2c_mbe_pkg::PH_S5: begin
                if (item.sda_in) begin
                    if (cmd_pre == i2c_mbe_pkg::OP_START) begin
                        status_next = i2c_mbe_pkg::ST_ERROR;
                        done        = 1'b1;
                    end else begin
                        pfail_next = 1'b1;
                    end
                end else if (cmd_pre == i2c_mbe_pkg::OP_START) begin
                    status_next = i2c_mbe_pkg::ST_OK;
                    done        = 1'b1;
                end else begin
                    if (cmd_pre == i2c_mbe_pkg::OP_COUNT) begin
                        shift_next = {paddr_pre, 1'b0};
                    end
                    bit_next = 4'd0;
                end
            end
            i2c_mbe_pkg::PH_BDATA: begin
                scl_next   = 1'b0;
                sda_next   = shift_pre[7];
                shift_next = {shift_pre[6:0], 1'b0};
            end
            i2c_mbe_pkg::PH_BHIGH: scl_next = 1'b1;
            i2c_mbe_pkg::PH_BLOW: begin
                scl_next = 1'b0;
                bit_next = bit_inc;
            end
            i2c_mbe_pkg::PH_A1: sda_next = 1'b1;
            i2c_mbe_pkg::PH_A2: begin
                scl_next = 1'b1;
                ack_next = timeout_reg;
            end
            i2c_mbe_pkg::PH_A3: begin
                if (!item.sda_in) begin
                    scl_next   = 1'b0;
                    pfail_next = 1'b0;
                    if (cmd_pre == i2c_mbe_pkg::OP_WRITE) begin
                        status_next = i2c_mbe_pkg::ST_OK;
                        done        = 1'b1;
                    end
                end else if (ack_expire) begin
                    ack_next   = 16'd0;
                    pfail_next = 1'b1;
                    sda_next   = 1'b0;
                end else begin
                    ack_next = ack_reg - 16'd1;
                end
            end
            i2c_mbe_pkg::PH_R0: begin
                sda_next   = 1'b1;
                scl_next   = 1'b0;
                shift_next = 8'd0;
                bit_next   = 4'd0;
            end
            i2c_mbe_pkg::PH_RHIGH: scl_next = 1'b1;
            i2c_mbe_pkg::PH_RLOW: begin
                shift_next = {shift_pre[6:0], item.sda_in};
                scl_next   = 1'b0;
                bit_next   = bit_inc;
            end
            i2c_mbe_pkg::PH_K1: sda_next = (cmd_pre == i2c_mbe_pkg::OP_READ_NACK);
            i2c_mbe_pkg::PH_K2: scl_next = 1'b1;
            i2c_mbe_pkg::PH_K3: begin
                scl_next    = 1'b0;
                rd_next     = shift_pre;
                status_next = i2c_mbe_pkg::ST_OK;
                done        = 1'b1;
            end
            i2c_mbe_pkg::PH_P1: sda_next = 1'b0;
            i2c_mbe_pkg::PH_P2: scl_next = 1'b1;
            i2c_mbe_pkg::PH_P3: begin
                sda_next = 1'b1;
                if (cmd_pre == i2c_mbe_pkg::OP_COUNT) begin
                    found_next = found_inc;
                    if (paddr_last) begin
                        cnt_next    = found_inc;
                        status_next = i2c_mbe_pkg::ST_OK;
                        done        = 1'b1;
                    end else begin
                        paddr_next = paddr_pre + 7'd1;
                    end
                end else begin
                    status_next = pfail_pre ? i2c_mbe_pkg::ST_NACK : i2c_mbe_pkg::ST_OK;
                    done        = 1'b1;
                end
            end
            default: begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= i2c_mbe_pkg::PH_IDLE;
            cmd_reg     <= i2c_mbe_pkg::OP_TICK;
            bit_reg     <= 4'd0;
            shift_reg   <= 8'd0;
            ack_reg     <= 16'd0;
            paddr_reg   <= 7'd0;
            found_reg   <= 8'd0;
            pfail_reg   <= 1'b0;
            status_reg  <= i2c_mbe_pkg::ST_OK;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            rd_reg      <= 8'd0;
            cnt_reg     <= 8'd0;
        end else if (adv) begin
            phase_reg   <= phase_next;
            cmd_reg     <= cmd_pre;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            ack_reg     <= ack_next;
            paddr_reg   <= paddr_next;
            found_reg   <= found_next;
            pfail_reg   <= pfail_next;
            status_reg  <= status_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            rd_reg      <= rd_next;
            cnt_reg     <= cnt_next;
        end
    end

    // A timeout of zero behaves as one, which the expiry compare already covers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= i2c_mbe_pkg::ACK_TIMEOUT_RESET;
        end else if (cfg_we) begin
            timeout_reg <= cfg_wdata;
        end
    end

    assign res.scl_out      = scl_next;
    assign res.sda_out      = sda_next;
    assign res.busy_res     = phase_next != i2c_mbe_pkg::PH_IDLE;
    assign res.done_res     = done;
    assign res.status       = status_next;
    assign res.rd_data      = rd_next;
    assign res.device_count = cnt_next;

endmodule

// ===== rtl/i2c_mbe_out_stage.sv =====
// Result register that holds one result item until the consumer takes it.
module i2c_mbe_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  i2c_mbe_pkg::res_t res_in,
    output logic              load_ok,
    output logic              m_valid,
    input  logic              m_ready,
    output i2c_mbe_pkg::res_t res_out
);

    logic              valid_reg;
    i2c_mbe_pkg::res_t res_reg;

    assign load_ok = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign res_out = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_ok) begin
            valid_reg <= adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_in;
        end
    end

endmodule

// ===== rtl/i2c_master_bit_engine_core.sv =====
// Top level of the I2C master bit engine: input register, sequencer, result register.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------------
//   s_       | s_valid / s_ready  | s_op, s_wr_data, s_sda_in
//   m_       | m_valid / m_ready  | m_scl_out, m_sda_out, m_busy_res, m_done_res,
//            |                    | m_status, m_rd_data, m_device_count
//   cfg_     | cfg_we             | cfg_wdata (ACK timeout in ticks)
//
// The sequencer performs one line action per item. One item is accepted every cycle
// while the result register is not stalled; the item is held in the input register,
// then its result in the result register. The phase register loop sets that rate.
// Reset is synchronous and active low and leaves both stages empty.
// A stalled result holds the sequencer and, one item later, the input side.
module i2c_master_bit_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [7:0]  s_wr_data,
    input  logic        s_sda_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_out,
    output logic        m_sda_out,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic [1:0]  m_status,
    output logic [7:0]  m_rd_data,
    output logic [7:0]  m_device_count,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    i2c_mbe_pkg::item_t item_in, item_q;
    i2c_mbe_pkg::res_t  res_d, res_q;
    logic               item_valid, load_ok, adv;

    assign item_in.op      = i2c_mbe_pkg::op_t'(s_op);
    assign item_in.wr_data = s_wr_data;
    assign item_in.sda_in  = s_sda_in;

    assign adv = item_valid && load_ok;

    i2c_mbe_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .item_in    (item_in),
        .adv        (adv),
        .item_valid (item_valid),
        .item_out   (item_q)
    );

    i2c_mbe_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .item      (item_q),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .res       (res_d)
    );

    i2c_mbe_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .res_in  (res_d),
        .load_ok (load_ok),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .res_out (res_q)
    );

    assign m_scl_out      = res_q.scl_out;
    assign m_sda_out      = res_q.sda_out;
    assign m_busy_res     = res_q.busy_res;
    assign m_done_res     = res_q.done_res;
    assign m_status       = res_q.status;
    assign m_rd_data      = res_q.rd_data;
    assign m_device_count = res_q.device_count;

endmodule

// ===== rtl/i2c_mbe_checker.sv =====
// Port-level checker for the I2C master bit engine and its bind.
`include "i2c_master_bit_engine_core_macros.svh"

module i2c_mbe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_scl_out,
    input logic        m_sda_out,
    input logic        m_busy_res,
    input logic        m_done_res,
    input logic [1:0]  m_status,
    input logic [7:0]  m_rd_data,
    input logic [7:0]  m_device_count
);

    logic [22:0] m_payload;

    assign m_payload = {m_scl_out, m_sda_out, m_busy_res, m_done_res, m_status,
                        m_rd_data, m_device_count};

    `MBE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))
    `MBE_ASSERT_SAME(a_done_not_busy, aclk, aresetn, m_valid && m_done_res, !m_busy_res)
    `MBE_ASSERT_SAME(a_count_range, aclk, aresetn, m_valid, m_device_count <= 8'd128)
    `MBE_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid && s_ready)

endmodule

bind i2c_master_bit_engine_core i2c_mbe_checker u_chk (.*);

// ===== test/testbench.sv =====
// Testbench for the I2C master bit engine: directed table, then random line traffic.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned STALL_LIMIT = 2000;

    typedef struct packed {
        i2c_mbe_pkg::op_t  op;
        logic [7:0]        wr;
        logic              sda;
        logic              pinned;
        i2c_mbe_pkg::res_t want;
    } dir_row_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_op = 3'd0;
    logic [7:0]  s_wr_data = 8'h00;
    logic        s_sda_in = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_scl_out;
    logic        m_sda_out;
    logic        m_busy_res;
    logic        m_done_res;
    logic [1:0]  m_status;
    logic [7:0]  m_rd_data;
    logic [7:0]  m_device_count;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;

    // The expectation typed into a table row travels with its item.
    logic              pin_row = 1'b0;
    i2c_mbe_pkg::res_t pin_state = '0;

    // Line model of the sequencer.
    logic [15:0]          ack_limit = i2c_mbe_pkg::ACK_TIMEOUT_RESET;
    i2c_mbe_pkg::phase_t  ph = i2c_mbe_pkg::PH_IDLE;
    i2c_mbe_pkg::op_t     cmd = i2c_mbe_pkg::OP_TICK;
    logic [3:0]           bit_idx = 4'd0;
    logic [7:0]           shreg = 8'h00;
    logic [15:0]          ack_left = 16'd0;
    logic [6:0]           probe_addr = 7'd0;
    logic [7:0]           found = 8'd0;
    i2c_mbe_pkg::status_t last_st = i2c_mbe_pkg::ST_OK;
    logic                 scl_lv = 1'b1;
    logic                 sda_lv = 1'b1;
    logic                 fail_pend = 1'b0;
    logic [7:0]           rd_byte = 8'h00;
    logic [7:0]           cnt_latch = 8'h00;
    logic                 done_now = 1'b0;

    i2c_mbe_pkg::res_t expected_lines[$];
    int unsigned       accepted_ticks = 0;
    int unsigned       faults = 0;
    int unsigned       quiet_cycles = 0;
    logic              idle_gaps = 1'b1;

    dir_row_t directed_rows [19] = '{
        '{i2c_mbe_pkg::OP_TICK, 8'h00, 1'b0, 1'b1,
          '{1'b1, 1'b1, 1'b0, 1'b0, i2c_mbe_pkg::ST_OK, 8'h00, 8'h00}},
        '{i2c_mbe_pkg::OP_START, 8'hFF, 1'b1, 1'b0, '0},
        '{i2c_mbe_pkg::OP_PROBE, 8'h00, 1'b1, 1'b0, '0},
        '{i2c_mbe_pkg::OP_TICK, 8'h00, 1'b0, 1'b1,
          '{1'b1, 1'b1, 1'b0, 1'b1, i2c_mbe_pkg::ST_BUSY, 8'h00, 8'h00}},
        '{i2c_mbe_pkg::OP_STOP, 8'h00, 1'b0, 1'b0, '0},
        '{i2c_mbe_pkg::OP_COUNT, 8'hFF, 1'b1, 1'b0, '0},
        '{i2c_mbe_pkg::OP_TICK, 8'h00, 1'b1, 1'b1,
          '{1'b1, 1'b1, 1'b0, 1'b1, i2c_mbe_pkg::ST_OK, 8'h00, 8'h00}},
        '{i2c_mbe_pkg::OP_START, 8'h00, 1'b0, 1'b0, '0},
        '{i2c_mbe_pkg::OP_TICK, 8'h00, 1'b1, 1'b0, '0},
        '{i2c_mbe_pkg::OP_READ_ACK, 8'hFF, 1'b1, 1'b0, '0},
        '{i2c_mbe_pkg::OP_TICK, 8'h00, 1'b0, 1'b0, '0},
        '{i2c_mbe_pkg::OP_TICK, 8'h00, 1'b1, 1'b1,
          '{1'b0, 1'b0, 1'b0, 1'b1, i2c_mbe_pkg::ST_ERROR, 8'h00, 8'h00}},
        '{i2c_mbe_pkg::OP_START, 8'h00, 1'b1, 1'b0, '0},
        '{i2c_mbe_pkg::OP_TICK, 8'h00, 1'b0, 1'b0, '0},
        '{i2c_mbe_pkg::OP_TICK, 8'h00, 1'b1, 1'b0, '0},
        '{i2c_mbe_pkg::OP_TICK, 8'h00, 1'b0, 1'b0, '0},
        '{i2c_mbe_pkg::OP_TICK, 8'h00, 1'b0, 1'b1,
          '{1'b0, 1'b0, 1'b0, 1'b1, i2c_mbe_pkg::ST_OK, 8'h00, 8'h00}},
        '{i2c_mbe_pkg::OP_WRITE, 8'hFF, 1'b1, 1'b0, '0},
        '{i2c_mbe_pkg::OP_READ_NACK, 8'h00, 1'b0, 1'b0, '0}
    };

    i2c_master_bit_engine_core uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_wr_data      (s_wr_data),
        .s_sda_in       (s_sda_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_scl_out      (m_scl_out),
        .m_sda_out      (m_sda_out),
        .m_busy_res     (m_busy_res),
        .m_done_res     (m_done_res),
        .m_status       (m_status),
        .m_rd_data      (m_rd_data),
        .m_device_count (m_device_count),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void close_cmd(input i2c_mbe_pkg::status_t st);
        last_st = st;
        ph = i2c_mbe_pkg::PH_IDLE;
        done_now = 1'b1;
    endfunction

    function automatic void line_action(input logic sda);
        case (ph)
            i2c_mbe_pkg::PH_S1: begin
                sda_lv = 1'b1;
                ph = i2c_mbe_pkg::PH_S2;
            end
            i2c_mbe_pkg::PH_S2: begin
                scl_lv = 1'b1;
                ph = i2c_mbe_pkg::PH_S3;
            end
            i2c_mbe_pkg::PH_S3: begin
                if (!sda) begin
                    if (cmd == i2c_mbe_pkg::OP_START) begin
                        close_cmd(i2c_mbe_pkg::ST_BUSY);
                    end else begin
                        fail_pend = 1'b1;
                        ph = i2c_mbe_pkg::PH_P1;
                    end
                end else begin
                    sda_lv = 1'b0;
                    ph = i2c_mbe_pkg::PH_S4;
                end
            end
            i2c_mbe_pkg::PH_S4: begin
                scl_lv = 1'b0;
                ph = i2c_mbe_pkg::PH_S5;
            end
            i2c_mbe_pkg::PH_S5: begin
                if (sda) begin
                    if (cmd == i2c_mbe_pkg::OP_START) begin
                        close_cmd(i2c_mbe_pkg::ST_ERROR);
                    end else begin
                        fail_pend = 1'b1;
                        ph = i2c_mbe_pkg::PH_P1;
                    end
                end else if (cmd == i2c_mbe_pkg::OP_START) begin
                    close_cmd(i2c_mbe_pkg::ST_OK);
                end else begin
                    if (cmd == i2c_mbe_pkg::OP_COUNT) shreg = {probe_addr, 1'b0};
                    bit_idx = 4'd0;
                    ph = i2c_mbe_pkg::PH_BDATA;
                end
            end
            i2c_mbe_pkg::PH_BDATA: begin
                scl_lv = 1'b0;
                sda_lv = shreg[7];
                shreg = {shreg[6:0], 1'b0};
                ph = i2c_mbe_pkg::PH_BHIGH;
            end
            i2c_mbe_pkg::PH_BHIGH: begin
                scl_lv = 1'b1;
                ph = i2c_mbe_pkg::PH_BLOW;
            end
            i2c_mbe_pkg::PH_BLOW: begin
                scl_lv = 1'b0;
                bit_idx = bit_idx + 4'd1;
                ph = (bit_idx >= 4'd8) ? i2c_mbe_pkg::PH_A1 : i2c_mbe_pkg::PH_BDATA;
            end
            i2c_mbe_pkg::PH_A1: begin
                sda_lv = 1'b1;
                ph = i2c_mbe_pkg::PH_A2;
            end
            i2c_mbe_pkg::PH_A2: begin
                scl_lv = 1'b1;
                ack_left = ack_limit;
                ph = i2c_mbe_pkg::PH_A3;
            end
            i2c_mbe_pkg::PH_A3: begin
                if (!sda) begin
                    scl_lv = 1'b0;
                    fail_pend = 1'b0;
                    if (cmd == i2c_mbe_pkg::OP_WRITE) close_cmd(i2c_mbe_pkg::ST_OK);
                    else ph = i2c_mbe_pkg::PH_P1;
                end else if (ack_left <= 16'd1) begin
                    ack_left = 16'd0;
                    fail_pend = 1'b1;
                    sda_lv = 1'b0;
                    ph = i2c_mbe_pkg::PH_P2;
                end else begin
                    ack_left = ack_left - 16'd1;
                end
            end
            i2c_mbe_pkg::PH_R0: begin
                sda_lv = 1'b1;
                scl_lv = 1'b0;
                shreg = 8'h00;
                bit_idx = 4'd0;
                ph = i2c_mbe_pkg::PH_RHIGH;
            end
            i2c_mbe_pkg::PH_RHIGH: begin
                scl_lv = 1'b1;
                ph = i2c_mbe_pkg::PH_RLOW;
            end
            i2c_mbe_pkg::PH_RLOW: begin
                shreg = {shreg[6:0], sda};
                scl_lv = 1'b0;
                bit_idx = bit_idx + 4'd1;
                ph = (bit_idx >= 4'd8) ? i2c_mbe_pkg::PH_K1 : i2c_mbe_pkg::PH_RHIGH;
            end
            i2c_mbe_pkg::PH_K1: begin
                sda_lv = (cmd == i2c_mbe_pkg::OP_READ_NACK);
                ph = i2c_mbe_pkg::PH_K2;
            end
            i2c_mbe_pkg::PH_K2: begin
                scl_lv = 1'b1;
                ph = i2c_mbe_pkg::PH_K3;
            end
            i2c_mbe_pkg::PH_K3: begin
                scl_lv = 1'b0;
                rd_byte = shreg;
                close_cmd(i2c_mbe_pkg::ST_OK);
            end
            i2c_mbe_pkg::PH_P1: begin
                sda_lv = 1'b0;
                ph = i2c_mbe_pkg::PH_P2;
            end
            i2c_mbe_pkg::PH_P2: begin
                scl_lv = 1'b1;
                ph = i2c_mbe_pkg::PH_P3;
            end
            i2c_mbe_pkg::PH_P3: begin
                sda_lv = 1'b1;
                if (cmd == i2c_mbe_pkg::OP_COUNT) begin
                    if (!fail_pend) found = found + 8'd1;
                    if ({1'b0, probe_addr} + 8'd1 >= i2c_mbe_pkg::ADDR_SPACE_LIM) begin
                        cnt_latch = found;
                        close_cmd(i2c_mbe_pkg::ST_OK);
                    end else begin
                        probe_addr = probe_addr + 7'd1;
                        ph = i2c_mbe_pkg::PH_S1;
                    end
                end else begin
                    close_cmd(fail_pend ? i2c_mbe_pkg::ST_NACK : i2c_mbe_pkg::ST_OK);
                end
            end
            default: ph = i2c_mbe_pkg::PH_IDLE;
        endcase
    endfunction

    function automatic i2c_mbe_pkg::res_t predict_tick(input i2c_mbe_pkg::op_t op,
                                                       input logic [7:0] wr,
                                                       input logic sda);
        i2c_mbe_pkg::res_t r;
        done_now = 1'b0;
        if (ph == i2c_mbe_pkg::PH_IDLE) begin
            if (op != i2c_mbe_pkg::OP_TICK) begin
                cmd = op;
                fail_pend = 1'b0;
                case (op)
                    i2c_mbe_pkg::OP_START: ph = i2c_mbe_pkg::PH_S1;
                    i2c_mbe_pkg::OP_STOP: ph = i2c_mbe_pkg::PH_P1;
                    i2c_mbe_pkg::OP_WRITE: begin
                        shreg = wr;
                        bit_idx = 4'd0;
                        ph = i2c_mbe_pkg::PH_BDATA;
                    end
                    i2c_mbe_pkg::OP_READ_ACK, i2c_mbe_pkg::OP_READ_NACK:
                        ph = i2c_mbe_pkg::PH_R0;
                    i2c_mbe_pkg::OP_PROBE: begin
                        shreg = wr;
                        ph = i2c_mbe_pkg::PH_S1;
                    end
                    default: begin
                        probe_addr = 7'd0;
                        found = 8'd0;
                        ph = i2c_mbe_pkg::PH_S1;
                    end
                endcase
                line_action(sda);
            end
        end else begin
            line_action(sda);
        end
        r.scl_out = scl_lv;
        r.sda_out = sda_lv;
        r.busy_res = (ph != i2c_mbe_pkg::PH_IDLE);
        r.done_res = done_now;
        r.status = last_st;
        r.rd_data = rd_byte;
        r.device_count = cnt_latch;
        return r;
    endfunction

    function automatic string show_line(input i2c_mbe_pkg::res_t r);
        return $sformatf("scl=%b sda=%b busy=%b done=%b status=%0d rd=%02h count=%0d",
                         r.scl_out, r.sda_out, r.busy_res, r.done_res, r.status,
                         r.rd_data, r.device_count);
    endfunction

    function automatic void check_line(input i2c_mbe_pkg::res_t want,
                                       input i2c_mbe_pkg::res_t got);
        if (want.scl_out !== got.scl_out || want.sda_out !== got.sda_out ||
            want.busy_res !== got.busy_res || want.done_res !== got.done_res ||
            want.status !== got.status || want.rd_data !== got.rd_data ||
            want.device_count !== got.device_count) begin
            faults++;
            if (faults <= 10)
                $display("mismatch at %0t: expected %s, got %s", $time,
                         show_line(want), show_line(got));
        end
    endfunction

    always @(posedge aclk) begin
        i2c_mbe_pkg::res_t got;
        i2c_mbe_pkg::res_t predicted;
        logic moved;
        if (aresetn) begin
            moved = 1'b0;
            if (m_valid === 1'b1 && m_ready) begin
                moved = 1'b1;
                got.scl_out = m_scl_out;
                got.sda_out = m_sda_out;
                got.busy_res = m_busy_res;
                got.done_res = m_done_res;
                got.status = i2c_mbe_pkg::status_t'(m_status);
                got.rd_data = m_rd_data;
                got.device_count = m_device_count;
                if (expected_lines.size() == 0) begin
                    faults++;
                    if (faults <= 10) $display("unexpected result: %s", show_line(got));
                end else begin
                    check_line(expected_lines.pop_front(), got);
                end
            end
            if (s_valid && s_ready === 1'b1) begin
                moved = 1'b1;
                predicted = predict_tick(i2c_mbe_pkg::op_t'(s_op), s_wr_data, s_sda_in);
                expected_lines.push_back(pin_row ? pin_state : predicted);
                accepted_ticks++;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        m_ready <= !idle_gaps || ($urandom_range(99) >= 17);
    end

    task automatic send_item(input i2c_mbe_pkg::op_t op, input logic [7:0] wr,
                             input logic sda, input logic pinned,
                             input i2c_mbe_pkg::res_t want);
        int unsigned target;
        target = accepted_ticks + 1;
        while (idle_gaps && $urandom_range(99) < 17) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_wr_data <= wr;
        s_sda_in <= sda;
        pin_row <= pinned;
        pin_state <= want;
        wait (accepted_ticks == target);
    endtask

    task automatic set_timeout(input logic [15:0] ticks);
        s_valid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= ticks;
        @(posedge aclk);
        cfg_we <= 1'b0;
        ack_limit = ticks;
    endtask

    // Commands run to completion; the SDA level is steered by phase so that most
    // starts see a free bus and most byte transfers reach the acknowledge slot.
    // During a device count most probes find the bus held low, which keeps the
    // sweep over all addresses short.
    task automatic run_random(input int unsigned budget, input logic force_count);
        int unsigned spent;
        int unsigned pick;
        i2c_mbe_pkg::op_t op;
        logic sda;
        logic want_nack;
        spent = 0;
        want_nack = 1'b0;
        while (spent < budget || ph != i2c_mbe_pkg::PH_IDLE) begin
            if (ph == i2c_mbe_pkg::PH_IDLE) begin
                pick = $urandom_range(99);
                if (pick < 15 && !force_count) begin
                    send_item(i2c_mbe_pkg::OP_TICK, 8'($urandom), 1'($urandom), 1'b0, '0);
                end else begin
                    pick = $urandom_range(99);
                    if (force_count) op = i2c_mbe_pkg::OP_COUNT;
                    else if (pick < 15) op = i2c_mbe_pkg::OP_START;
                    else if (pick < 25) op = i2c_mbe_pkg::OP_STOP;
                    else if (pick < 50) op = i2c_mbe_pkg::OP_WRITE;
                    else if (pick < 62) op = i2c_mbe_pkg::OP_READ_ACK;
                    else if (pick < 74) op = i2c_mbe_pkg::OP_READ_NACK;
                    else op = i2c_mbe_pkg::OP_PROBE;
                    force_count = 1'b0;
                    want_nack = ($urandom_range(99) < 25);
                    send_item(op, 8'($urandom), 1'($urandom), 1'b0, '0);
                    spent++;
                end
            end else begin
                if (ph == i2c_mbe_pkg::PH_S1) want_nack = ($urandom_range(99) < 25);
                case (ph)
                    i2c_mbe_pkg::PH_S3:
                        sda = (cmd == i2c_mbe_pkg::OP_COUNT) ? ($urandom_range(99) < 2)
                                                             : ($urandom_range(99) < 88);
                    i2c_mbe_pkg::PH_S5: sda = ($urandom_range(99) < 12);
                    i2c_mbe_pkg::PH_A3: sda = (want_nack && ack_limit <= 16'd40) ? 1'b1
                                              : ($urandom_range(99) >= 45);
                    default: sda = 1'($urandom);
                endcase
                if (cmd != i2c_mbe_pkg::OP_COUNT && $urandom_range(99) < 5)
                    sda = 1'($urandom);
                op = ($urandom_range(99) < 10) ? i2c_mbe_pkg::op_t'($urandom_range(7))
                                               : i2c_mbe_pkg::OP_TICK;
                send_item(op, 8'($urandom), sda, 1'b0, '0);
                spent++;
            end
        end
    endtask

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge aclk);
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].wr, directed_rows[i].sda,
                      directed_rows[i].pinned, directed_rows[i].want);
        run_random(40, 1'b0);
        set_timeout(16'd0);
        run_random(30, 1'b0);
        set_timeout(16'd1);
        run_random(30, 1'b0);
        set_timeout(16'hFFFF);
        idle_gaps = 1'b0;
        run_random(40, 1'b0);
        set_timeout(16'd3);
        run_random(1, 1'b1);
        idle_gaps = 1'b1;
        set_timeout(16'($urandom_range(30, 2)));
        run_random(30, 1'b0);
        s_valid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (faults == 0 && expected_lines.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
